@@ sv/rpp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rpp_pkg;

   localparam int MAX_WAYPOINTS = 256;
   localparam int ADDR_W = $clog2(MAX_WAYPOINTS);
   localparam int LEN_W = $clog2(MAX_WAYPOINTS + 1);

   localparam int DIV_W = 64;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam int WP_W = 64;

   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_APPEND  = 2'd1,
      REQ_CONTROL = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_code_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ sv/regulated_pure_pursuit_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Regulated pure-pursuit path follower.
// Input channel (req_*): clear path, append waypoint, or control step. A beat is
// taken when req_valid is high and req_stall low. Clear and append give no
// result; append to a full path is dropped.
// Result channel (rsp_*): one beat per control step, held in an output register
// until rsp_stall is low; the next request is taken while it waits.
// A control step scans waypoints from the goal end (one memory read, difference,
// square and compare per waypoint), then normalizes, may take a square root and
// runs up to three divisions on the shared serial divider. An empty path
// answers without a scan. One item is worked on at a time.
// csr_*: write-only register port, used while the block is idle.
// Reset (synchronous) restores register defaults and empties the path; the
// waypoint memory is not cleared, only entries below the length are used.

module regulated_pure_pursuit_controller
   import rpp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_type,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [15:0] req_heading_cos,
   input  wire logic signed [15:0] req_heading_sin,
   input  wire logic [7:0]         req_cell_cost,
   input  wire logic               req_cost_valid,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [19:0]             rsp_linear_speed,
   output logic signed [20:0]      rsp_angular_speed,
   output logic [7:0]              rsp_carrot_index,
   output logic                    rsp_path_empty,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [23:0]        csr_wdata
);

   localparam logic [2:0] CSR_LOOKAHEAD = 3'd0;
   localparam logic [2:0] CSR_VMAX      = 3'd1;
   localparam logic [2:0] CSR_VMIN      = 3'd2;
   localparam logic [2:0] CSR_WMAX      = 3'd3;
   localparam logic [2:0] CSR_GAIN      = 3'd4;
   localparam logic [2:0] CSR_SLOWDOWN  = 3'd5;
   localparam logic [2:0] CSR_COST      = 3'd6;

   localparam logic [48:0] CURV_EPS   = 49'd4295;
   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [16:0] SCALE_MIN  = 17'd19661;
   localparam int          SCALE_KNEE = 65536 - 19661;
   // ceil(2^39 / 255), exact floor division by 255 for any 32-bit numerator
   localparam logic [31:0] RECIP_255  = 32'h80808081;

   typedef enum logic [4:0] {
      S_IDLE, S_DIFF, S_SQ, S_CMP, S_ROT1, S_ROT2, S_MAG, S_NORM, S_D2, S_K0,
      S_KDIV, S_GK1, S_GK2, S_VDEN, S_VDIV, S_SQRT, S_RMUL, S_RDIV, S_COST,
      S_CRCP, S_CSCL, S_CMUL, S_CLAMP, S_WMUL, S_WCLAMP, S_OUT
   } state_type;

   state_type state_ff;

   logic [23:0] cfg_la_ff, cfg_gain_ff, cfg_sd_ff, cfg_cost_ff;
   logic [19:0] cfg_vmax_ff, cfg_vmin_ff, cfg_wmax_ff;

   logic [LEN_W-1:0]  path_len_ff;
   logic [ADDR_W-1:0] i_ff, idx_ff;

   logic signed [31:0] rx_ff, ry_ff;
   logic signed [15:0] hc_ff, hs_ff;
   logic [7:0]         cost_ff;
   logic               costv_ff;

   logic signed [32:0] dx_ff, dy_ff, cdx_ff, cdy_ff;
   logic [47:0]        sqx_ff, sqy_ff, lsq_ff, sdsq_ff;
   logic               far_ff, goal_near_ff;
   logic [48:0]        goal_d2_ff;
   logic signed [48:0] px1_ff, px2_ff, px3_ff, px4_ff;
   logic signed [35:0] xr_ff, yr_ff;
   logic [35:0]        nax_ff, nay_ff;
   logic [3:0]         sh_ff;
   logic               ysign_ff;
   logic [33:0]        kmag_ff;
   logic signed [34:0] ks_ff;
   logic [40:0]        pa_ff, pb_ff;
   logic [19:0]        v_ff;
   logic [48:0]        sq_x_ff, sq_r_ff, sq_bit_ff;
   logic [31:0]        cnum_ff;
   logic [23:0]        cq_ff;
   logic [16:0]        scale_ff;
   logic signed [55:0] wprod_ff;

   logic [19:0]        res_lin_ff;
   logic signed [20:0] res_ang_ff;
   logic [7:0]         res_idx_ff;
   logic               res_empty_ff;

   logic               rsp_valid_ff;
   logic [19:0]        rsp_lin_ff;
   logic signed [20:0] rsp_ang_ff;
   logic [7:0]         rsp_idx_ff;
   logic               rsp_empty_ff;

   logic               req_accept;
   logic [LEN_W-1:0]   last_w;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [WP_W-1:0]    ram_rd_data;
   logic signed [31:0] ram_x, ram_y;
   logic [32:0]        ax, ay;
   logic [48:0]        d2;
   logic               beyond, first;
   logic signed [49:0] xs, ys;
   logic [49:0]        sq_trial;
   logic [63:0]        cq_prod;
   logic [36:0]        cprod;
   logic [19:0]        vlo;
   logic signed [39:0] wsh, wlim;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign last_w     = path_len_ff - LEN_W'(1);

   assign ram_we = req_accept && req_type == REQ_APPEND
                   && path_len_ff < LEN_W'(MAX_WAYPOINTS);
   assign ram_rd_addr = (state_ff == S_IDLE) ? last_w[ADDR_W-1:0] : i_ff - ADDR_W'(1);

   rpp_ram #(.WIDTH(WP_W), .DEPTH(MAX_WAYPOINTS)) u_path (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (path_len_ff[ADDR_W-1:0]),
      .wr_data ({req_pos_y, req_pos_x}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rpp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign ram_x = $signed(ram_rd_data[31:0]);
   assign ram_y = $signed(ram_rd_data[63:32]);

   assign ax = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ay = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);

   assign d2     = 49'(sqx_ff) + 49'(sqy_ff);
   assign beyond = far_ff || d2 > 49'(lsq_ff);
   assign first  = i_ff == last_w[ADDR_W-1:0];

   assign xs = 50'(px1_ff) + 50'(px2_ff);
   assign ys = 50'(px3_ff) - 50'(px4_ff);

   assign sq_trial = 50'(sq_r_ff) + 50'(sq_bit_ff);
   assign cq_prod  = 64'(cnum_ff) * 64'(RECIP_255);
   assign cprod    = 37'(v_ff) * 37'(scale_ff);
   assign vlo      = (v_ff < cfg_vmin_ff) ? cfg_vmin_ff : v_ff;
   assign wsh      = wprod_ff[55:16];
   assign wlim     = $signed(40'(cfg_wmax_ff));

   always_comb begin
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;
      case (state_ff)
         S_K0: begin
            div_req.start = !((sh_ff == 4'd0 && d2 < CURV_EPS) || d2 == 49'd0);
            div_req.num   = DIV_W'({nay_ff[23:0], 33'd0});
            div_req.den   = DIV_W'(d2);
         end
         S_VDEN: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'({cfg_vmax_ff, 32'd0});
            div_req.den   = DIV_W'(60'(pa_ff) + (60'(pb_ff) << 17) + (60'(1) << 32));
         end
         S_RMUL: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(45'(v_ff) * 45'(sq_r_ff[24:0]));
            div_req.den   = DIV_W'(cfg_sd_ff);
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_la_ff   <= 24'd39322;
         cfg_vmax_ff <= 20'd22938;
         cfg_vmin_ff <= 20'd3277;
         cfg_wmax_ff <= 20'd78643;
         cfg_gain_ff <= 24'd131072;
         cfg_sd_ff   <= 24'd52429;
         cfg_cost_ff <= 24'd65536;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOOKAHEAD: cfg_la_ff   <= csr_wdata;
            CSR_VMAX:      cfg_vmax_ff <= csr_wdata[19:0];
            CSR_VMIN:      cfg_vmin_ff <= csr_wdata[19:0];
            CSR_WMAX:      cfg_wmax_ff <= csr_wdata[19:0];
            CSR_GAIN:      cfg_gain_ff <= csr_wdata;
            CSR_SLOWDOWN:  cfg_sd_ff   <= csr_wdata;
            CSR_COST:      cfg_cost_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         path_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a waiting result in S_OUT reloads the register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  rx_ff    <= req_pos_x;
                  ry_ff    <= req_pos_y;
                  hc_ff    <= req_heading_cos;
                  hs_ff    <= req_heading_sin;
                  cost_ff  <= req_cell_cost;
                  costv_ff <= req_cost_valid;
                  i_ff     <= last_w[ADDR_W-1:0];
                  case (req_type)
                     REQ_CLEAR: path_len_ff <= '0;
                     REQ_APPEND: begin
                        if (ram_we) begin
                           path_len_ff <= path_len_ff + LEN_W'(1);
                        end
                     end
                     REQ_CONTROL: begin
                        if (path_len_ff == '0) begin
                           res_lin_ff   <= '0;
                           res_ang_ff   <= '0;
                           res_idx_ff   <= '0;
                           res_empty_ff <= 1'b1;
                           state_ff     <= S_OUT;
                        end else begin
                           state_ff <= S_DIFF;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_DIFF: begin
               dx_ff    <= 33'(ram_x) - 33'(rx_ff);
               dy_ff    <= 33'(ram_y) - 33'(ry_ff);
               lsq_ff   <= 48'(cfg_la_ff) * 48'(cfg_la_ff);
               sdsq_ff  <= 48'(cfg_sd_ff) * 48'(cfg_sd_ff);
               state_ff <= S_SQ;
            end
            S_SQ: begin
               far_ff   <= (|ax[32:24]) || (|ay[32:24]);
               sqx_ff   <= 48'(ax[23:0]) * 48'(ax[23:0]);
               sqy_ff   <= 48'(ay[23:0]) * 48'(ay[23:0]);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (first) begin
                  goal_d2_ff   <= d2;
                  goal_near_ff <= !far_ff;
               end
               // carrot is the lowest index of the beyond run at the goal end, or the goal if that run is empty
               if (beyond || first) begin
                  cdx_ff <= dx_ff;
                  cdy_ff <= dy_ff;
                  idx_ff <= i_ff;
               end
               if (beyond && i_ff != '0) begin
                  i_ff     <= i_ff - ADDR_W'(1);
                  state_ff <= S_DIFF;
               end else begin
                  state_ff <= S_ROT1;
               end
            end
            S_ROT1: begin
               px1_ff   <= 49'(hc_ff) * 49'(cdx_ff);
               px2_ff   <= 49'(hs_ff) * 49'(cdy_ff);
               px3_ff   <= 49'(hc_ff) * 49'(cdy_ff);
               px4_ff   <= 49'(hs_ff) * 49'(cdx_ff);
               state_ff <= S_ROT2;
            end
            S_ROT2: begin
               xr_ff    <= xs[49:14];
               yr_ff    <= ys[49:14];
               state_ff <= S_MAG;
            end
            S_MAG: begin
               nax_ff   <= xr_ff[35] ? 36'(-xr_ff) : 36'(xr_ff);
               nay_ff   <= yr_ff[35] ? 36'(-yr_ff) : 36'(yr_ff);
               ysign_ff <= yr_ff[35];
               sh_ff    <= '0;
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if ((|nax_ff[35:24]) || (|nay_ff[35:24])) begin
                  nax_ff <= nax_ff >> 1;
                  nay_ff <= nay_ff >> 1;
                  sh_ff  <= sh_ff + 4'd1;
               end else begin
                  state_ff <= S_D2;
               end
            end
            S_D2: begin
               sqx_ff   <= 48'(nax_ff[23:0]) * 48'(nax_ff[23:0]);
               sqy_ff   <= 48'(nay_ff[23:0]) * 48'(nay_ff[23:0]);
               state_ff <= S_K0;
            end
            S_K0: begin
               if (div_req.start) begin
                  state_ff <= S_KDIV;
               end else begin
                  kmag_ff  <= '0;
                  state_ff <= S_GK1;
               end
            end
            S_KDIV: begin
               if (div_rsp.done) begin
                  kmag_ff  <= 34'(div_rsp.quot >> sh_ff);
                  state_ff <= S_GK1;
               end
            end
            S_GK1: begin
               pa_ff    <= 41'(cfg_gain_ff) * 41'(kmag_ff[16:0]);
               ks_ff    <= ysign_ff ? -35'(kmag_ff) : 35'(kmag_ff);
               state_ff <= S_GK2;
            end
            S_GK2: begin
               pb_ff    <= 41'(cfg_gain_ff) * 41'(kmag_ff[33:17]);
               state_ff <= S_VDEN;
            end
            S_VDEN: begin
               state_ff <= S_VDIV;
            end
            S_VDIV: begin
               if (div_rsp.done) begin
                  v_ff <= div_rsp.quot[19:0];
                  if (goal_near_ff && cfg_sd_ff != '0 && goal_d2_ff < 49'(sdsq_ff)) begin
                     sq_x_ff   <= goal_d2_ff;
                     sq_r_ff   <= '0;
                     sq_bit_ff <= 49'(1) << 48;
                     state_ff  <= S_SQRT;
                  end else begin
                     state_ff <= S_COST;
                  end
               end
            end
            S_SQRT: begin
               // one result bit per step, two radicand bits
               if (50'(sq_x_ff) >= sq_trial) begin
                  sq_x_ff <= sq_x_ff - sq_trial[48:0];
                  sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_r_ff <= sq_r_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               if (sq_bit_ff == 49'd1) begin
                  state_ff <= S_RMUL;
               end
            end
            S_RMUL: begin
               state_ff <= S_RDIV;
            end
            S_RDIV: begin
               if (div_rsp.done) begin
                  v_ff     <= div_rsp.quot[19:0];
                  state_ff <= S_COST;
               end
            end
            S_COST: begin
               cnum_ff  <= 32'(cfg_cost_ff) * 32'(cost_ff);
               state_ff <= costv_ff ? S_CRCP : S_CLAMP;
            end
            S_CRCP: begin
               // divide by 255 through the reciprocal
               cq_ff    <= cq_prod[62:39];
               state_ff <= S_CSCL;
            end
            S_CSCL: begin
               if (cq_ff > 24'(SCALE_KNEE)) begin
                  scale_ff <= SCALE_MIN;
               end else begin
                  scale_ff <= ONE_Q16 - cq_ff[16:0];
               end
               state_ff <= S_CMUL;
            end
            S_CMUL: begin
               v_ff     <= cprod[35:16];
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               // min first, then max, so max wins when limits cross
               v_ff     <= (vlo > cfg_vmax_ff) ? cfg_vmax_ff : vlo;
               state_ff <= S_WMUL;
            end
            S_WMUL: begin
               wprod_ff <= 56'(ks_ff) * 56'($signed({1'b0, v_ff}));
               state_ff <= S_WCLAMP;
            end
            S_WCLAMP: begin
               if (wsh > wlim) begin
                  res_ang_ff <= 21'(wlim);
               end else if (wsh < -wlim) begin
                  res_ang_ff <= 21'(-wlim);
               end else begin
                  res_ang_ff <= 21'(wsh);
               end
               res_lin_ff   <= v_ff;
               res_idx_ff   <= 8'(idx_ff);
               res_empty_ff <= 1'b0;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_lin_ff   <= res_lin_ff;
                  rsp_ang_ff   <= res_ang_ff;
                  rsp_idx_ff   <= res_idx_ff;
                  rsp_empty_ff <= res_empty_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_linear_speed  = rsp_lin_ff;
   assign rsp_angular_speed = rsp_ang_ff;
   assign rsp_carrot_index  = rsp_idx_ff;
   assign rsp_path_empty    = rsp_empty_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      path_len_ff <= LEN_W'(MAX_WAYPOINTS))
      else $error("path length beyond capacity");

   a_scan_in_path: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> LEN_W'(i_ff) < path_len_ff)
      else $error("scan index outside stored path");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_KDIV || state_ff == S_VDIV
                        || state_ff == S_RDIV))
      else $error("divider result arrived outside a wait state");

endmodule

`default_nettype wire

@@ sv/rpp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/rpp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpp_div
   import rpp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     den_ff;

   logic [DIV_W:0]       rem_sh;
   logic                 take;

   // restoring division, one quotient bit per cycle
   assign rem_sh = {rem_ff, quo_ff[DIV_W-1]};
   assign take   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_W);
            rem_ff  <= '0;
            quo_ff  <= div_req.num;
            den_ff  <= div_req.den;
         end else if (busy_ff) begin
            rem_ff <= take ? DIV_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], take};
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff == DIV_CNT_W'(1) |=> done_ff)
      else $error("divider missed its done beat");

endmodule

`default_nettype wire

@@ tb/regulated_pure_pursuit_controller_tb.sv @@
`timescale 1ns / 1ps

module regulated_pure_pursuit_controller_tb;
   import rpp_pkg::*;

   localparam longint unsigned NEAR_LIMIT = 64'd1 << 24;
   localparam longint unsigned CURV_EPS = 64'd4295;
   localparam longint COST_SCALE_MIN = 19661;
   localparam longint ONE_Q16 = 65536;
   localparam int ITEM_TARGET = 800;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 400;

   typedef enum logic [2:0] {
      REG_LOOKAHEAD  = 3'd0,
      REG_MAX_LINEAR = 3'd1,
      REG_MIN_LINEAR = 3'd2,
      REG_MAX_ANGLE  = 3'd3,
      REG_CURV_GAIN  = 3'd4,
      REG_SLOW_DIST  = 3'd5,
      REG_COST_SCALE = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [19:0]        linear;
      logic signed [20:0] angular;
      logic [7:0]         carrot;
      logic               empty;
   } command_type;

   typedef struct {
      req_code_type       op;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] hc;
      logic signed [15:0] hs;
      logic [7:0]         cost;
      logic               cv;
      bit                 typed;
      command_type        cmd;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [15:0] req_heading_cos = '0;
   logic signed [15:0] req_heading_sin = '0;
   logic [7:0] req_cell_cost = '0;
   logic req_cost_valid = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [19:0] rsp_linear_speed;
   logic signed [20:0] rsp_angular_speed;
   logic [7:0] rsp_carrot_index;
   logic rsp_path_empty;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   regulated_pure_pursuit_controller i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_heading_cos(req_heading_cos), .req_heading_sin(req_heading_sin),
      .req_cell_cost(req_cell_cost), .req_cost_valid(req_cost_valid),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_linear_speed(rsp_linear_speed), .rsp_angular_speed(rsp_angular_speed),
      .rsp_carrot_index(rsp_carrot_index), .rsp_path_empty(rsp_path_empty),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   longint unsigned lookahead, max_lin, min_lin, max_ang, curv_gain, slow_dist, cost_weight;
   longint waypoint_x [MAX_WAYPOINTS];
   longint waypoint_y [MAX_WAYPOINTS];
   int path_len;

   command_type commands_due[$];
   int mismatches = 0;
   int beats_sent = 0;
   int commands_seen = 0;
   int idle_cycles = 0;
   bit calm = 0;

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   function automatic bit beyond_radius(longint dx, longint dy);
      longint unsigned ax, ay;
      ax = magnitude(dx);
      ay = magnitude(dy);
      if (ax >= NEAR_LIMIT || ay >= NEAR_LIMIT) return 1;
      return ax * ax + ay * ay > lookahead * lookahead;
   endfunction

   function automatic longint arc_curvature(longint xr, longint yr);
      longint unsigned ax, ay, d2, kq;
      int sh;
      ax = magnitude(xr);
      ay = magnitude(yr);
      sh = 0;
      while (ax >= NEAR_LIMIT || ay >= NEAR_LIMIT) begin
         ax >>= 1;
         ay >>= 1;
         sh++;
      end
      d2 = ax * ax + ay * ay;
      if ((sh == 0 && d2 < CURV_EPS) || d2 == 0) return 0;
      kq = ((ay * 64'd2) << 32) / d2;
      kq >>= sh;
      return yr < 0 ? -longint'(kq) : longint'(kq);
   endfunction

   // updates the path and returns 1 with the command when the beat gives one
   function automatic bit pursuit_command(input req_code_type op, input longint rx, ry,
         input longint c, s, input longint unsigned cost, input bit cv,
         output command_type cmd);
      longint dx, dy, xr, yr, k, w, scale;
      longint unsigned v, ax, ay, d2;
      int idx;
      cmd = '0;
      case (op)
         REQ_CLEAR: begin
            path_len = 0;
            return 0;
         end
         REQ_APPEND: begin
            if (path_len < MAX_WAYPOINTS) begin
               waypoint_x[path_len] = rx;
               waypoint_y[path_len] = ry;
               path_len++;
            end
            return 0;
         end
         REQ_CONTROL: ;
         default: return 0;
      endcase
      if (path_len == 0) begin
         cmd.empty = 1'b1;
         return 1;
      end
      // scan back from the goal while waypoints lie outside the radius
      idx = path_len - 1;
      for (int i = path_len - 1; i >= 0; i--) begin
         if (!beyond_radius(waypoint_x[i] - rx, waypoint_y[i] - ry)) break;
         idx = i;
      end
      dx = waypoint_x[idx] - rx;
      dy = waypoint_y[idx] - ry;
      xr = (c * dx + s * dy) >>> 14;
      yr = (c * dy - s * dx) >>> 14;
      k = arc_curvature(xr, yr);
      v = (max_lin << 32) / ((64'd1 << 32) + curv_gain * magnitude(k));
      ax = magnitude(waypoint_x[path_len - 1] - rx);
      ay = magnitude(waypoint_y[path_len - 1] - ry);
      if (ax < NEAR_LIMIT && ay < NEAR_LIMIT) begin
         d2 = ax * ax + ay * ay;
         if (slow_dist != 0 && d2 < slow_dist * slow_dist)
            v = v * int_sqrt(d2) / slow_dist;
      end
      if (cv) begin
         scale = ONE_Q16 - longint'((cost_weight * cost) / 64'd255);
         if (scale < COST_SCALE_MIN) scale = COST_SCALE_MIN;
         if (scale > ONE_Q16) scale = ONE_Q16;
         v = (v * longint'(scale)) >> 16;
      end
      if (v < min_lin) v = min_lin;
      if (v > max_lin) v = max_lin;
      w = (k * longint'(v)) >>> 16;
      if (w > longint'(max_ang)) w = longint'(max_ang);
      if (w < -longint'(max_ang)) w = -longint'(max_ang);
      cmd.linear = v[19:0];
      cmd.angular = w[20:0];
      cmd.carrot = idx[7:0];
      return 1;
   endfunction

   task automatic send_req(input req_code_type op, input logic signed [31:0] x, y,
         input logic signed [15:0] hc, hs, input logic [7:0] cost, input logic cv,
         input bit typed, input command_type typed_cmd);
      int gap;
      command_type cmd;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_pos_x <= x;
      req_pos_y <= y;
      req_heading_cos <= hc;
      req_heading_sin <= hs;
      req_cell_cost <= cost;
      req_cost_valid <= cv;
      do @(posedge clock); while (req_stall);
      if (pursuit_command(op, 64'(x), 64'(y), 64'(hc), 64'(hs), 64'(cost), cv, cmd))
         commands_due.push_back(typed ? typed_cmd : cmd);
      if (op != REQ_UNUSED) beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (commands_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [23:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_LOOKAHEAD:  lookahead = 64'(val);
         REG_MAX_LINEAR: max_lin = 64'(val[19:0]);
         REG_MIN_LINEAR: min_lin = 64'(val[19:0]);
         REG_MAX_ANGLE:  max_ang = 64'(val[19:0]);
         REG_CURV_GAIN:  curv_gain = 64'(val);
         REG_SLOW_DIST:  slow_dist = 64'(val);
         REG_COST_SCALE: cost_weight = 64'(val);
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [23:0] la, ml, mn, ma, cg, sd, cs);
      write_reg(REG_LOOKAHEAD, la);
      write_reg(REG_MAX_LINEAR, ml);
      write_reg(REG_MIN_LINEAR, mn);
      write_reg(REG_MAX_ANGLE, ma);
      write_reg(REG_CURV_GAIN, cg);
      write_reg(REG_SLOW_DIST, sd);
      write_reg(REG_COST_SCALE, cs);
   endtask

   task automatic send_control(input longint x, y);
      real ang;
      logic signed [15:0] hc, hs;
      if ($urandom_range(0, 9) == 0) begin
         hc = 16'($urandom_range(0, 32768) - 16384);
         hs = 16'($urandom_range(0, 32768) - 16384);
      end else begin
         ang = $urandom_range(0, 6283) / 1000.0;
         hc = 16'($rtoi($cos(ang) * 16384.0));
         hs = 16'($rtoi($sin(ang) * 16384.0));
      end
      send_req(REQ_CONTROL, 32'(x), 32'(y), hc, hs, 8'($urandom), 1'($urandom), 1'b0, '0);
   endtask

   // clear, then a path of n waypoints along a random direction, then controls near it
   task automatic run_path(input int n, input int controls);
      longint bx, by, px, py, sx, sy;
      real ang;
      int pick;
      bx = longint'($urandom_range(0, 13107200)) - 6553600;
      by = longint'($urandom_range(0, 13107200)) - 6553600;
      ang = $urandom_range(0, 6283) / 1000.0;
      send_req(REQ_CLEAR, $urandom, $urandom, '0, '0, '0, 1'b0, 1'b0, '0);
      px = bx;
      py = by;
      for (int i = 0; i < n; i++) begin
         sx = $urandom_range(3000, 40000);
         px += $rtoi($cos(ang) * sx) + $urandom_range(0, 4000) - 2000;
         py += $rtoi($sin(ang) * sx) + $urandom_range(0, 4000) - 2000;
         send_req(REQ_APPEND, 32'(px), 32'(py), '0, '0, '0, 1'b0, 1'b0, '0);
      end
      for (int j = 0; j < controls; j++) begin
         pick = $urandom_range(0, path_len > 0 ? path_len - 1 : 0);
         send_control(waypoint_x[pick] + $urandom_range(0, 65536) - 32768,
                      waypoint_y[pick] + $urandom_range(0, 65536) - 32768);
      end
   endtask

   task automatic run_phase(input int count);
      int stop, r;
      stop = beats_sent + count;
      while (beats_sent < stop) begin
         r = $urandom_range(0, 19);
         if (r < 16) begin
            run_path($urandom_range(1, 8), $urandom_range(1, 4));
         end else if (r == 16) begin
            send_req(req_code_type'($urandom_range(0, 3)), $urandom, $urandom,
                     16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
         end else if (r == 17) begin
            send_control(64'($urandom), 64'($urandom));
         end else if (r == 18) begin
            // extra waypoint on the current path, far or near
            send_req(REQ_APPEND, $urandom, $urandom, '0, '0, '0, 1'b0, 1'b0, '0);
            send_control(path_len > 0 ? waypoint_x[0] : 64'sd0,
                         path_len > 0 ? waypoint_y[0] : 64'sd0);
         end else begin
            send_req(REQ_CLEAR, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0);
            send_control(64'($urandom), 64'($urandom));
         end
      end
   endtask

   stim_row_type directed [19] = '{
      '{REQ_CONTROL, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 8'd0, 1'b0, 1'b1,
        '{20'd0, 21'sd0, 8'd0, 1'b1}},
      '{REQ_UNUSED, 32'sd5, 32'sd5, 16'sd0, 16'sd0, 8'd255, 1'b1, 1'b0, '0},
      '{REQ_APPEND, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0, 1'b0, '0},
      '{REQ_CONTROL, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 8'd0, 1'b0, 1'b0, '0},
      '{REQ_APPEND, 32'sd32768, 32'sd16384, 16'sd0, 16'sd0, 8'd0, 1'b0, 1'b0, '0},
      '{REQ_APPEND, 32'sd65536, 32'sd32768, 16'sd0, 16'sd0, 8'd0, 1'b0, 1'b0, '0},
      '{REQ_CONTROL, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 8'd255, 1'b1, 1'b0, '0},
      '{REQ_CONTROL, 32'sd0, 32'sd0, -16'sd16384, 16'sd0, 8'd0, 1'b1, 1'b0, '0},
      '{REQ_CONTROL, 32'sd0, 32'sd0, 16'sd0, 16'sd16384, 8'd128, 1'b1, 1'b0, '0},
      '{REQ_CONTROL, 32'sd65536, 32'sd32768, 16'sd0, -16'sd16384, 8'd0, 1'b0, 1'b0, '0},
      '{REQ_APPEND, 32'h7fffffff, 32'h80000000, 16'sd0, 16'sd0, 8'd0, 1'b0, 1'b0, '0},
      '{REQ_CONTROL, 32'sd0, 32'sd0, 16'sd11585, 16'sd11585, 8'd255, 1'b1, 1'b0, '0},
      '{REQ_CONTROL, 32'h80000000, 32'h7fffffff, -16'sd16384, 16'sd16384, 8'd255, 1'b0,
        1'b0, '0},
      '{REQ_APPEND, 32'sd1, -32'sd1, 16'sd0, 16'sd0, 8'd0, 1'b0, 1'b0, '0},
      '{REQ_CONTROL, 32'sd1, -32'sd1, 16'sd16384, 16'sd0, 8'd60, 1'b1, 1'b0, '0},
      '{REQ_CLEAR, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0, 1'b0, '0},
      '{REQ_CONTROL, -32'sd1, -32'sd1, 16'sd0, 16'sd0, 8'd255, 1'b1, 1'b1,
        '{20'd0, 21'sd0, 8'd0, 1'b1}},
      '{REQ_APPEND, -32'sd65536, 32'sd655360, 16'sd0, 16'sd0, 8'd0, 1'b0, 1'b0, '0},
      '{REQ_CONTROL, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 8'd0, 1'b0, 1'b0, '0}
   };

   // result side
   initial begin
      command_type want, got;
      int n;
      forever begin
         n = calm ? 0 : $urandom_range(0, 8);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         got = '{rsp_linear_speed, rsp_angular_speed, rsp_carrot_index, rsp_path_empty};
         commands_seen++;
         if (commands_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: lin %0d ang %0d carrot %0d empty %0b",
                        got.linear, got.angular, got.carrot, got.empty);
         end else begin
            want = commands_due.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected lin %0d ang %0d carrot %0d empty %0b, got lin %0d ang %0d carrot %0d empty %0b",
                           commands_seen, want.linear, want.angular, want.carrot, want.empty,
                           got.linear, got.angular, got.carrot, got.empty);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      lookahead = 39322;
      max_lin = 22938;
      min_lin = 3277;
      max_ang = 78643;
      curv_gain = 131072;
      slow_dist = 52429;
      cost_weight = 65536;
      path_len = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_req(directed[i].op, directed[i].x, directed[i].y, directed[i].hc,
                  directed[i].hs, directed[i].cost, directed[i].cv, directed[i].typed,
                  directed[i].cmd);
      run_phase(120);

      drain();
      write_all(24'hffffff, 24'h0fffff, 24'h0fffff, 24'h0fffff, 24'hffffff, 24'hffffff,
                24'hffffff);
      run_phase(70);

      // all registers zero, slowdown distance and limits included
      drain();
      write_all(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      run_phase(50);

      // inverted speed limits, no idling on either side
      drain();
      write_all(24'd45875, 24'd6554, 24'd30000, 24'd98304, 24'd65536, 24'd65536, 24'd200000);
      calm = 1;
      run_phase(80);
      calm = 0;

      drain();
      write_all(24'd39322, 24'd22938, 24'd3277, 24'd78643, 24'd131072, 24'd52429, 24'd65536);
      // full path, then appends that must be dropped
      run_path(MAX_WAYPOINTS + 4, 3);

      while (beats_sent < ITEM_TARGET) begin
         drain();
         write_all(24'($urandom_range(0, 200000)), 24'($urandom_range(0, 262144)),
                   24'($urandom_range(0, 40000)), 24'($urandom_range(0, 400000)),
                   24'($urandom_range(0, 1000000)), 24'($urandom_range(1, 300000)),
                   24'($urandom_range(0, 500000)));
         run_phase(60);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d request beats sent, %0d results checked over several register settings",
               beats_sent, commands_seen);
      if (mismatches == 0 && commands_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, commands_due.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
